>>> sv/sca_pkg.sv
// Shared types, constants and class tables for the size-class slab allocator.
// No dependencies.
package sca_pkg;

    localparam int ZONE_PAGES  = 16;
    localparam int PAGE_BYTES  = 4096;
    localparam int CLASS_COUNT = 6;
    localparam int HDR_BYTES   = 8;
    localparam int SLOT_BITS   = 13;               // 8-byte slots in the zone
    localparam int LINK_BITS   = SLOT_BITS + 1;    // one extra code for no slot
    localparam int PAGE_BITS   = 4;
    localparam int SPP_BITS    = 9;                // slots per page, log2
    localparam logic [LINK_BITS-1:0] NO_SLOT = LINK_BITS'(1) << SLOT_BITS;

    localparam logic [1:0] K_ALLOC = 2'd0;
    localparam logic [1:0] K_FREE  = 2'd1;
    localparam logic [1:0] K_QUERY = 2'd2;

    localparam logic [2:0] ST_OK   = 3'd0;
    localparam logic [2:0] ST_NULL = 3'd1;
    localparam logic [2:0] ST_BIG  = 3'd2;
    localparam logic [2:0] ST_EXH  = 3'd3;
    localparam logic [2:0] ST_BAD  = 3'd4;

    typedef enum logic [3:0] {
        CMD_NONE, CMD_LATCH, CMD_DECODE, CMD_FILL, CMD_POP_RD, CMD_POP_WR,
        CMD_FREE_RD, CMD_FREE_WR, CMD_RET_RD, CMD_RET_WK, CMD_RET_END, CMD_EMIT
    } t_cmd;

    typedef struct packed {
        logic dec_ok;
        logic is_alloc;
        logic is_free;
        logic need_fill;
        logic fill_last;
        logic do_retire;
        logic walk_end;
        logic out_free;
    } t_dp_stat;

    typedef struct packed {
        logic                 on_list;
        logic [LINK_BITS-1:0] link;
    } t_slot;

    function automatic logic [8:0] f_csize(input logic [2:0] c);
        return 9'(32'd8 << c);
    endfunction

    function automatic logic [9:0] f_objs(input logic [2:0] c);
        return 10'((PAGE_BYTES - HDR_BYTES) >> (32'(c) + 3));
    endfunction

endpackage

>>> sv/sca_ctrl.sv
// Sequencer for the slab allocator: walks each transaction through decode,
// page carve, list pop/push and page retire. Depends on sca_pkg.
module sca_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  sca_pkg::t_dp_stat i_stat,
    output sca_pkg::t_cmd     o_cmd
);
    import sca_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE    = 11'b00000000001,
        S_DECODE  = 11'b00000000010,
        S_FILL    = 11'b00000000100,
        S_POP_RD  = 11'b00000001000,
        S_POP_WR  = 11'b00000010000,
        S_FREE_RD = 11'b00000100000,
        S_FREE_WR = 11'b00001000000,
        S_RET_RD  = 11'b00010000000,
        S_RET_WK  = 11'b00100000000,
        S_RET_END = 11'b01000000000,
        S_DONE    = 11'b10000000000
    } t_state;

    t_state r_state, n_state;

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = CMD_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd   = CMD_LATCH;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd = CMD_DECODE;
                if (!i_stat.dec_ok)          n_state = S_DONE;
                else if (i_stat.is_alloc)    n_state = i_stat.need_fill ? S_FILL : S_POP_RD;
                else if (i_stat.is_free)     n_state = S_FREE_RD;
                else                         n_state = S_DONE;
            end
            S_FILL: begin
                o_cmd = CMD_FILL;
                if (i_stat.fill_last) n_state = S_POP_RD;
            end
            S_POP_RD: begin
                o_cmd   = CMD_POP_RD;
                n_state = S_POP_WR;
            end
            S_POP_WR: begin
                o_cmd   = CMD_POP_WR;
                n_state = S_DONE;
            end
            S_FREE_RD: begin
                o_cmd   = CMD_FREE_RD;
                n_state = S_FREE_WR;
            end
            S_FREE_WR: begin
                o_cmd   = CMD_FREE_WR;
                n_state = i_stat.do_retire ? S_RET_RD : S_DONE;
            end
            S_RET_RD: begin
                if (i_stat.walk_end) begin
                    n_state = S_RET_END;
                end else begin
                    o_cmd   = CMD_RET_RD;
                    n_state = S_RET_WK;
                end
            end
            S_RET_WK: begin
                o_cmd   = CMD_RET_WK;
                n_state = S_RET_RD;
            end
            S_RET_END: begin
                o_cmd   = CMD_RET_END;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd   = CMD_EMIT;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

endmodule

>>> sv/sca_dp.sv
// Datapath of the slab allocator: list heads, page table, link memory,
// counters and the result register. Depends on sca_pkg.
module sca_dp (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  sca_pkg::t_cmd         i_cmd,
    output sca_pkg::t_dp_stat     o_stat,
    input  logic [1:0]            i_kind,
    input  logic [15:0]           i_request_size,
    input  logic [15:0]           i_object_address,
    input  logic                  i_address_is_null,
    input  logic                  i_cfg_wr,
    input  logic [4:0]            i_cfg_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [15:0]           o_granted_address,
    output logic [8:0]            o_class_bytes,
    output logic [2:0]            o_status,
    output logic [4:0]            o_live_page_total,
    output logic [12:0]           o_free_object_total
);
    import sca_pkg::*;

    // latched transaction
    logic [1:0]  r_kind;
    logic [15:0] r_size;
    logic [15:0] r_addr;
    logic        r_null;

    // allocator state
    logic [LINK_BITS-1:0] r_head [CLASS_COUNT];
    logic [ZONE_PAGES-1:0] r_plive;
    logic [2:0]  r_pclass [ZONE_PAGES];
    logic [9:0]  r_pfree  [ZONE_PAGES];
    logic [4:0]  r_fresh;
    logic [4:0]  r_live;
    logic [12:0] r_free;
    logic [4:0]  r_limit;

    // working registers
    logic [2:0]  r_cls;
    logic [PAGE_BITS-1:0] r_page;
    logic [2:0]  r_status;
    logic [15:0] r_granted;
    logic [8:0]  r_cbytes;
    logic [8:0]  r_k;
    logic [SLOT_BITS-1:0] r_wslot;
    logic [LINK_BITS-1:0] r_prev;
    logic [LINK_BITS-1:0] r_cur;
    logic        r_ovalid;

    // link memory
    t_slot r_mem [1 << SLOT_BITS];
    t_slot r_rd;
    logic  mem_we, mem_re;
    logic [SLOT_BITS-1:0] mem_waddr, mem_raddr;
    t_slot mem_wdata;

    // decode
    logic [2:0]  calc_cls;
    logic        calc_found;
    logic [PAGE_BITS-1:0] a_page;
    logic [11:0] a_off, a_rel;
    logic [2:0]  a_cls;
    logic        loc_ok;
    logic [4:0]  limit;
    logic        head_empty;
    logic [2:0]  dec_status;
    logic [2:0]  dec_cls;

    logic [SLOT_BITS-1:0] step;
    logic [9:0]  objs;
    logic        fill_last;
    logic [SLOT_BITS-1:0] free_slot;
    logic [SLOT_BITS-1:0] pop_slot;
    logic [LINK_BITS-1:0] nx;

    always_comb begin
        calc_cls   = 3'd0;
        calc_found = 1'b0;
        for (int c = CLASS_COUNT - 1; c >= 0; c--) begin
            if (16'(f_csize(3'(c))) >= r_size) begin
                calc_cls   = 3'(c);
                calc_found = 1'b1;
            end
        end
    end

    assign a_page = r_addr[15:12];
    assign a_off  = r_addr[11:0];
    assign a_rel  = a_off - 12'(HDR_BYTES);
    assign a_cls  = r_pclass[a_page];
    // shift amount needs 4 bits: the 256-byte class shifts by 8
    assign loc_ok = r_plive[a_page] && (a_off >= 12'(HDR_BYTES))
                 && ((a_rel & 12'(f_csize(a_cls) - 9'd1)) == 12'd0)
                 && (10'(a_rel >> ({1'b0, a_cls} + 4'd3)) < f_objs(a_cls));
    assign limit      = (r_limit > 5'(ZONE_PAGES)) ? 5'(ZONE_PAGES) : r_limit;
    assign head_empty = r_head[calc_cls][SLOT_BITS];

    always_comb begin
        dec_status = ST_OK;
        dec_cls    = a_cls;
        case (r_kind)
            K_ALLOC: begin
                dec_cls = calc_cls;
                if (r_size == 16'd0)                   dec_status = ST_NULL;
                else if (!calc_found)                  dec_status = ST_BIG;
                else if (head_empty && r_fresh >= limit) dec_status = ST_EXH;
            end
            K_FREE, K_QUERY: begin
                if (r_null)       dec_status = ST_NULL;
                else if (!loc_ok) dec_status = ST_BAD;
            end
            default: dec_status = ST_BAD;
        endcase
    end

    assign step      = SLOT_BITS'(1) << r_cls;
    assign objs      = f_objs(r_cls);
    assign fill_last = ({1'b0, r_k} == objs - 10'd1);
    assign free_slot = r_addr[15:3];
    assign pop_slot  = r_head[r_cls][SLOT_BITS-1:0];
    assign nx        = r_rd.link;

    always_comb begin
        o_stat.dec_ok    = (dec_status == ST_OK);
        o_stat.is_alloc  = (r_kind == K_ALLOC);
        o_stat.is_free   = (r_kind == K_FREE);
        o_stat.need_fill = head_empty;
        o_stat.fill_last = fill_last;
        o_stat.do_retire = !r_rd.on_list && (r_pfree[r_page] + 10'd1 == objs);
        o_stat.walk_end  = r_cur[SLOT_BITS];
        o_stat.out_free  = !r_ovalid || !i_out_stall;
    end

    // memory port control
    always_comb begin
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_waddr = r_wslot;
        mem_raddr = pop_slot;
        mem_wdata = '{on_list: 1'b1, link: NO_SLOT};
        case (i_cmd)
            CMD_FILL: begin
                mem_we = 1'b1;
                mem_wdata.link = fill_last ? NO_SLOT : {1'b0, r_wslot + step};
            end
            CMD_POP_RD: mem_re = 1'b1;
            CMD_POP_WR: begin
                mem_we    = 1'b1;
                mem_waddr = pop_slot;
                mem_wdata = '{on_list: 1'b0, link: nx};
            end
            CMD_FREE_RD: begin
                mem_re    = 1'b1;
                mem_raddr = free_slot;
            end
            CMD_FREE_WR: begin
                mem_we    = !r_rd.on_list;
                mem_waddr = free_slot;
                mem_wdata = '{on_list: 1'b1, link: r_head[r_cls]};
            end
            CMD_RET_RD: begin
                mem_re    = 1'b1;
                mem_raddr = r_cur[SLOT_BITS-1:0];
            end
            CMD_RET_WK: begin
                // unlink: patch the previous survivor's link
                mem_we    = (r_cur[SLOT_BITS-1:SPP_BITS] == r_page) && !r_prev[SLOT_BITS];
                mem_waddr = r_prev[SLOT_BITS-1:0];
                mem_wdata = '{on_list: 1'b1, link: nx};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_waddr] <= mem_wdata;
        if (mem_re) r_rd <= r_mem[mem_raddr];
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        case (i_cmd)
            CMD_LATCH: begin
                r_kind <= i_kind;
                r_size <= i_request_size;
                r_addr <= i_object_address;
                r_null <= i_address_is_null;
            end
            CMD_DECODE: begin
                r_status  <= dec_status;
                r_cls     <= dec_cls;
                r_page    <= (r_kind == K_ALLOC) ? r_fresh[PAGE_BITS-1:0] : a_page;
                r_granted <= 16'd0;
                r_cbytes  <= (dec_status == ST_OK && r_kind != K_FREE) ? f_csize(dec_cls)
                                                                      : 9'd0;
                r_k       <= 9'd0;
                r_wslot   <= {r_fresh[PAGE_BITS-1:0], SPP_BITS'(HDR_BYTES / 8)};
            end
            CMD_FILL: begin
                r_k     <= r_k + 9'd1;
                r_wslot <= r_wslot + step;
                if (fill_last) begin
                    r_pclass[r_page] <= r_cls;
                end
            end
            CMD_POP_WR: r_granted <= {pop_slot, 3'b000};
            CMD_FREE_WR: begin
                if (r_rd.on_list) begin
                    r_status <= ST_BAD;
                end else begin
                    r_cbytes <= f_csize(r_cls);
                    r_cur    <= {1'b0, free_slot};
                    r_prev   <= NO_SLOT;
                end
            end
            CMD_RET_WK: begin
                if (r_cur[SLOT_BITS-1:SPP_BITS] != r_page) r_prev <= r_cur;
                r_cur <= nx;
            end
            default: ;
        endcase
    end

    // page free counts are only read for live pages
    always_ff @(posedge i_clk) begin
        case (i_cmd)
            CMD_FILL:    if (fill_last) r_pfree[r_page] <= objs;
            CMD_POP_WR:  r_pfree[pop_slot[SLOT_BITS-1:SPP_BITS]] <=
                             r_pfree[pop_slot[SLOT_BITS-1:SPP_BITS]] - 10'd1;
            CMD_FREE_WR: if (!r_rd.on_list) r_pfree[r_page] <= r_pfree[r_page] + 10'd1;
            CMD_RET_END: r_pfree[r_page] <= 10'd0;
            default: ;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CLASS_COUNT; c++) r_head[c] <= NO_SLOT;
            r_plive  <= '0;
            r_fresh  <= 5'd0;
            r_live   <= 5'd0;
            r_free   <= 13'd0;
            r_limit  <= 5'd16;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_wr) r_limit <= i_cfg_data;
            if (i_cmd == CMD_EMIT)  r_ovalid <= 1'b1;
            else if (!i_out_stall)  r_ovalid <= 1'b0;
            case (i_cmd)
                CMD_FILL: begin
                    if (fill_last) begin
                        r_head[r_cls]  <= {1'b0, r_page, SPP_BITS'(HDR_BYTES / 8)};
                        r_plive[r_page] <= 1'b1;
                        r_fresh        <= r_fresh + 5'd1;
                        r_live         <= r_live + 5'd1;
                        r_free         <= r_free + 13'(objs);
                    end
                end
                CMD_POP_WR: begin
                    r_head[r_cls] <= nx;
                    r_free        <= r_free - 13'd1;
                end
                CMD_FREE_WR: begin
                    if (!r_rd.on_list) begin
                        r_head[r_cls] <= {1'b0, free_slot};
                        r_free        <= r_free + 13'd1;
                    end
                end
                CMD_RET_WK: begin
                    if (r_cur[SLOT_BITS-1:SPP_BITS] == r_page && r_prev[SLOT_BITS])
                        r_head[r_cls] <= nx;
                end
                CMD_RET_END: begin
                    r_free          <= r_free - 13'(r_pfree[r_page]);
                    r_plive[r_page] <= 1'b0;
                    r_live          <= r_live - 5'd1;
                end
                default: ;
            endcase
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd == CMD_EMIT) begin
            o_granted_address   <= r_granted;
            o_class_bytes       <= r_cbytes;
            o_status            <= r_status;
            o_live_page_total   <= r_live;
            o_free_object_total <= r_free;
        end
    end

    assign o_out_valid = r_ovalid;

endmodule

>>> sv/size_class_slab_allocator_core.sv
// Top level of the size-class slab allocator: sequencer plus datapath.
// Depends on sca_pkg, sca_ctrl, sca_dp.
//
// channel | direction | handshake                  | payload
// in      | input     | i_in_valid / o_in_stall    | kind, request_size, object_address, null
// out     | output    | o_out_valid / i_out_stall  | granted, class bytes, status, totals
// cfg     | input     | i_cfg_valid / o_cfg_ready  | zone_page_limit (5 bits)
//
// One transaction at a time. Pop or push: latch, decode, link read, link write, output wait.
// A fresh page adds a carve step per object (15 to 511), one link memory write each.
// A page retire adds a read and walk step per class list node, then end check, count update.
// Reset is synchronous; the link memory needs no clearing.
// A stalled result holds in the output register while the next item is accepted.
module size_class_slab_allocator_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_kind,
    input  logic [15:0] i_request_size,
    input  logic [15:0] i_object_address,
    input  logic        i_address_is_null,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_granted_address,
    output logic [8:0]  o_class_bytes,
    output logic [2:0]  o_status,
    output logic [4:0]  o_live_page_total,
    output logic [12:0] o_free_object_total,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [4:0]  i_cfg_data
);
    import sca_pkg::*;

    t_cmd     cmd;
    t_dp_stat stat;

    assign o_cfg_ready = 1'b1;

    sca_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    sca_dp u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_stat              (stat),
        .i_kind              (i_kind),
        .i_request_size      (i_request_size),
        .i_object_address    (i_object_address),
        .i_address_is_null   (i_address_is_null),
        .i_cfg_wr            (i_cfg_valid & o_cfg_ready),
        .i_cfg_data          (i_cfg_data),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_granted_address   (o_granted_address),
        .o_class_bytes       (o_class_bytes),
        .o_status            (o_status),
        .o_live_page_total   (o_live_page_total),
        .o_free_object_total (o_free_object_total)
    );

endmodule

>>> verif/slab_checker.sv
// Checker for the size-class slab allocator: watches the in, out and config channels,
// keeps a shadow allocator and compares every result. Depends on sca_pkg.
`timescale 1ns / 100ps
module slab_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [1:0]  i_kind,
    input  logic [15:0] i_request_size,
    input  logic [15:0] i_object_address,
    input  logic        i_address_is_null,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [15:0] i_granted_address,
    input  logic [8:0]  i_class_bytes,
    input  logic [2:0]  i_status,
    input  logic [4:0]  i_live_page_total,
    input  logic [12:0] i_free_object_total,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [4:0]  i_cfg_data,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_result_count
);
    import sca_pkg::*;

    localparam int SPP = PAGE_BYTES / 8;
    localparam int TOTAL = ZONE_PAGES * SPP;
    localparam int NONE = TOTAL;

    typedef struct packed {
        logic [15:0] granted;
        logic [8:0]  cbytes;
        logic [2:0]  status;
        logic [4:0]  live;
        logic [12:0] free_n;
    } t_alloc_result;

    t_alloc_result result_queue[$];
    int  head_slot[CLASS_COUNT];
    int  next_slot[TOTAL];
    bit  slot_free[TOTAL];
    bit  pg_live[ZONE_PAGES];
    int  pg_class[ZONE_PAGES];
    int  pg_free[ZONE_PAGES];
    int  fresh_page, live_pages, free_objs, zone_limit;

    function automatic int class_objs(int c);
        return (PAGE_BYTES - HDR_BYTES) / (8 << c);
    endfunction

    function automatic void shadow_reset();
        for (int c = 0; c < CLASS_COUNT; c++) head_slot[c] = NONE;
        for (int s = 0; s < TOTAL; s++) begin
            next_slot[s] = 0;
            slot_free[s] = 0;
        end
        for (int p = 0; p < ZONE_PAGES; p++) begin
            pg_live[p] = 0;
            pg_class[p] = 0;
            pg_free[p] = 0;
        end
        fresh_page = 0;
        live_pages = 0;
        free_objs = 0;
        zone_limit = 16;
    endfunction

    function automatic void carve_page(int c);
        int n, step, base, s;
        n = class_objs(c);
        step = (8 << c) / 8;
        base = fresh_page * SPP + HDR_BYTES / 8;
        for (int k = 0; k < n; k++) begin
            s = base + k * step;
            next_slot[s] = (k + 1 < n) ? s + step : NONE;
            slot_free[s] = 1;
        end
        head_slot[c] = base;
        pg_live[fresh_page] = 1;
        pg_class[fresh_page] = c;
        pg_free[fresh_page] = n;
        fresh_page++;
        live_pages++;
        free_objs += n;
    endfunction

    function automatic void retire_page(int p);
        int c, prev, cur, nx;
        c = pg_class[p];
        prev = NONE;
        cur = head_slot[c];
        while (cur != NONE) begin
            nx = next_slot[cur];
            if (cur / SPP == p) begin
                slot_free[cur] = 0;
                if (prev == NONE) head_slot[c] = nx;
                else next_slot[prev] = nx;
            end else begin
                prev = cur;
            end
            cur = nx;
        end
        free_objs -= pg_free[p];
        pg_free[p] = 0;
        pg_live[p] = 0;
        live_pages--;
    endfunction

    // returns slot of a valid object start in a live page, else NONE
    function automatic int find_slot(int addr);
        int p, off, sz;
        p = addr / PAGE_BYTES;
        off = addr % PAGE_BYTES;
        if (p >= ZONE_PAGES || !pg_live[p] || off < HDR_BYTES) return NONE;
        sz = 8 << pg_class[p];
        if ((off - HDR_BYTES) % sz != 0 || (off - HDR_BYTES) / sz >= class_objs(pg_class[p]))
            return NONE;
        return addr / 8;
    endfunction

    function automatic t_alloc_result predict_alloc(logic [1:0] kind, int size, int addr,
                                                    bit is_null);
        t_alloc_result r;
        int c, s, p, lim;
        r = '0;
        r.status = ST_OK;
        if (kind == K_ALLOC) begin
            c = 0;
            while (c < CLASS_COUNT && (8 << c) < size) c++;
            if (size == 0) r.status = ST_NULL;
            else if (c >= CLASS_COUNT || class_objs(c) == 0) r.status = ST_BIG;
            else begin
                lim = zone_limit < ZONE_PAGES ? zone_limit : ZONE_PAGES;
                if (head_slot[c] == NONE) begin
                    if (fresh_page >= lim) r.status = ST_EXH;
                    else carve_page(c);
                end
                if (r.status == ST_OK) begin
                    s = head_slot[c];
                    head_slot[c] = next_slot[s];
                    slot_free[s] = 0;
                    pg_free[s / SPP]--;
                    free_objs--;
                    r.granted = 16'(s * 8);
                    r.cbytes = 9'(8 << c);
                end
            end
        end else if (kind == K_FREE || kind == K_QUERY) begin
            if (is_null) r.status = ST_NULL;
            else begin
                s = find_slot(addr);
                if (s == NONE || (kind == K_FREE && slot_free[s])) r.status = ST_BAD;
                else begin
                    p = s / SPP;
                    c = pg_class[p];
                    r.cbytes = 9'(8 << c);
                    if (kind == K_FREE) begin
                        next_slot[s] = head_slot[c];
                        head_slot[c] = s;
                        slot_free[s] = 1;
                        pg_free[p]++;
                        free_objs++;
                        if (pg_free[p] == class_objs(c)) retire_page(p);
                    end
                end
            end
        end else begin
            r.status = ST_BAD;
        end
        r.live = 5'(live_pages);
        r.free_n = 13'(free_objs);
        return r;
    endfunction

    initial begin
        shadow_reset();
        o_fail_count = 0;
        o_result_count = 0;
    end

    assign o_pending = result_queue.size();

    always @(posedge i_clk) begin
        t_alloc_result exp_r, got_r;
        if (i_rst_n) begin
            if (i_cfg_valid && i_cfg_ready) zone_limit = i_cfg_data;
            if (i_out_valid && !i_out_stall) begin
                got_r = '{i_granted_address, i_class_bytes, i_status, i_live_page_total,
                          i_free_object_total};
                o_result_count <= o_result_count + 1;
                if (result_queue.size() == 0) begin
                    if (o_fail_count < 10) $display("unexpected result %p", got_r);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_r = result_queue.pop_front();
                    if (got_r !== exp_r) begin
                        if (o_fail_count < 10)
                            $display("mismatch: expected %p got %p", exp_r, got_r);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            // predict after the pop so an output register bypass cannot race the queue
            if (i_in_valid && !i_in_stall)
                result_queue.push_back(predict_alloc(i_kind, i_request_size,
                                                     i_object_address, i_address_is_null));
        end
    end
endmodule

>>> verif/testbench.sv
// Stimulus and verdict for the size-class slab allocator.
// Depends on sca_pkg, size_class_slab_allocator_core and slab_checker.
`timescale 1ns / 100ps
module testbench;
    import sca_pkg::*;

    logic        clk = 0, rst_n = 0;
    logic        in_valid = 0, in_stall, out_valid, out_stall = 0;
    logic [1:0]  kind = K_ALLOC;
    logic [15:0] req_size = 0, obj_addr = 0;
    logic        addr_null = 0;
    logic [15:0] granted;
    logic [8:0]  cbytes;
    logic [2:0]  status;
    logic [4:0]  live_total;
    logic [12:0] free_total;
    logic        cfg_valid = 0, cfg_ready;
    logic [4:0]  cfg_data = 0;
    int          fail_count, pending, result_count;
    int          held_addr[$];
    bit          stall_on = 1;

    always #6 clk = ~clk;

    size_class_slab_allocator_core uut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_kind(kind), .i_request_size(req_size),
        .i_object_address(obj_addr), .i_address_is_null(addr_null),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_granted_address(granted), .o_class_bytes(cbytes), .o_status(status),
        .o_live_page_total(live_total), .o_free_object_total(free_total),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready), .i_cfg_data(cfg_data)
    );

    slab_checker chk (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall),
        .i_kind(kind), .i_request_size(req_size),
        .i_object_address(obj_addr), .i_address_is_null(addr_null),
        .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_granted_address(granted), .i_class_bytes(cbytes), .i_status(status),
        .i_live_page_total(live_total), .i_free_object_total(free_total),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending), .o_result_count(result_count)
    );

    // receiver stall pattern, switched off for some phases
    always @(posedge clk) begin
        out_stall <= stall_on ? ($urandom_range(0, 3) == 0) : 1'b0;
    end

    // track granted objects so random frees mostly hit live objects
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall && status == ST_OK && granted != 0
                && cbytes != 0)
            held_addr.push_back(granted);
    end

    task automatic send_op(logic [1:0] k, int size, int addr, bit nul);
        in_valid <= 1'b1;
        kind <= k;
        req_size <= 16'(size);
        obj_addr <= 16'(addr);
        addr_null <= nul;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if ($urandom_range(0, 7) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic drain_all();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (1200) @(posedge clk);
    endtask

    task automatic write_limit(int value);
        cfg_valid <= 1'b1;
        cfg_data <= 5'(value);
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // pick a request that is mostly well formed, sometimes broken
    task automatic random_op();
        int r, idx, a;
        r = $urandom_range(0, 99);
        if (r < 45) send_op(K_ALLOC, $urandom_range(1, 256), $urandom, 0);
        else if (r < 80 && held_addr.size() > 0) begin
            idx = $urandom_range(0, held_addr.size() - 1);
            a = held_addr[idx];
            held_addr.delete(idx);
            send_op(K_FREE, $urandom, a, 0);
        end else if (r < 88 && held_addr.size() > 0) begin
            send_op(K_QUERY, $urandom, held_addr[$urandom_range(0, held_addr.size() - 1)], 0);
        end else begin
            send_op(2'($urandom), $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 300),
                    $urandom, $urandom_range(0, 1));
        end
    endtask

    initial begin
        int limits[4] = '{16, 1, 3, 31};
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: edges of each field and special cases other than zone exhaustion
        send_op(K_ALLOC, 0, 0, 0);          // zero size
        send_op(K_ALLOC, 1, 0, 0);
        send_op(K_ALLOC, 8, 0, 0);
        send_op(K_ALLOC, 9, 0, 0);
        send_op(K_ALLOC, 256, 0, 0);
        send_op(K_ALLOC, 257, 0, 0);        // too large
        send_op(K_ALLOC, 65535, 16'hFFFF, 1);
        send_op(K_QUERY, 0, 8, 0);
        send_op(K_QUERY, 0, 8, 1);          // null pointer
        send_op(K_FREE, 0, 8, 0);
        send_op(K_FREE, 0, 8, 0);           // double free
        send_op(K_FREE, 0, 0, 0);           // header
        send_op(K_FREE, 0, 12, 0);          // misaligned
        send_op(K_FREE, 0, 16'hFFFF, 0);    // page never live
        send_op(2'd3, 16'hFFFF, 16'hFFFF, 1); // unused kind
        send_op(K_ALLOC, 128, 0, 0);
        send_op(K_ALLOC, 128, 0, 0);
        send_op(K_QUERY, 0, 16'h1FF8, 0);
        drain_all();
        held_addr.delete();

        foreach (limits[i]) begin
            write_limit(limits[i]);
            for (int n = 0; n < 475; n++) begin
                if (n == 240) stall_on = !stall_on;
                random_op();
            end
            drain_all();
        end

        $display("ran directed edge cases and random alloc/free/query traffic");
        $display("over zone limits 16, 1, 3, 31; %0d results checked", result_count);
        if (fail_count == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("end of test: mismatches");
        $finish;
    end
endmodule
